/* hdl/bbcd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbcd_pkg
// Shared types and constants of the block buffer cache directory.
// ---------------------------------------------------------------------------
package bbcd_pkg;

  localparam int DEVICES = 4;
  localparam int ENTRIES = 16;
  localparam int SLOT_W  = 4;
  localparam int DEV_W   = 2;
  localparam int ADDR_W  = 64;
  localparam int CIDX_W  = 3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  // opcodes
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_FILL      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_FLUSH_DEV = 3'd3;
  localparam logic [2:0] OP_FLUSH_ALL = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_DEV    = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR   = 2'd2;
  localparam logic [1:0] ST_FLUSH_FAIL = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_NUM_DEVICES = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BLOCKS0     = 3'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_CMP,
    S_FIN,
    S_ALLOC
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
  } tag_t;

  typedef struct packed {
    logic req_dev_ok;
    logic req_addr_ok;
    logic ent_dev_ok;
  } chk_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              stored;
    logic              writeback;
    logic [DEV_W-1:0]  wb_device;
    logic [ADDR_W-1:0] wb_block_addr;
    logic              last;
  } res_t;

endpackage

/* hdl/bbcd_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bbcd_cfg_regs
// Device count and per-device block counts, with the device and address
// range checks built on them.
// ---------------------------------------------------------------------------
module bbcd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbcd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bbcd_pkg::ADDR_W-1:0]   cfg_data,
  input  logic [7:0]                    req_dev,
  input  logic [bbcd_pkg::ADDR_W-1:0]   req_addr,
  input  logic [bbcd_pkg::DEV_W-1:0]    ent_dev,
  output bbcd_pkg::chk_t                chk
);
  import bbcd_pkg::*;

  logic [2:0]        num_devices;
  logic [ADDR_W-1:0] blocks [DEVICES];
  logic [CIDX_W-1:0] boff;

  assign cfg_ready = 1'b1;
  assign boff      = cfg_index - CFG_BLOCKS0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_devices <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        blocks[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_DEVICES: num_devices <= cfg_data[2:0];
        default: begin
          // indexes past the last block count register are dropped
          if (cfg_index >= CFG_BLOCKS0 && boff < CIDX_W'(DEVICES)) begin
            blocks[boff[DEV_W-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  always_comb begin
    chk.req_dev_ok  = (req_dev < {5'b0, num_devices}) && (req_dev < 8'(DEVICES));
    chk.req_addr_ok = req_addr < blocks[req_dev[DEV_W-1:0]];
    chk.ent_dev_ok  = ({1'b0, ent_dev} < num_devices) && ({1'b0, ent_dev} < 3'(DEVICES));
  end

endmodule

/* hdl/block_buffer_cache_directory.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_buffer_cache_directory
// Tag/state directory of a fully associative write-back block cache.
// ---------------------------------------------------------------------------
// One transaction at a time: accept and check states, then a walk over the 16
// entries (S_RD per entry, S_CMP after a read of the registered tag RAM) that
// ends at a read or write hit, then a result state, plus S_ALLOC for a write
// that misses. Fill skips the walk; errors and unused opcodes end at the check.
// Reset clears valid/dirty flops, config registers and output valid; the tag
// RAM is not cleared and is only read for valid entries.
module block_buffer_cache_directory (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbcd_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bbcd_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  device,
  input  logic [bbcd_pkg::ADDR_W-1:0] block_addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        hit,
  output logic [bbcd_pkg::SLOT_W-1:0] slot,
  output logic                        stored,
  output logic                        writeback,
  output logic [bbcd_pkg::DEV_W-1:0]  wb_device,
  output logic [bbcd_pkg::ADDR_W-1:0] wb_block_addr,
  output logic                        last
);
  import bbcd_pkg::*;

  state_t            state, state_next;
  logic [2:0]        op;
  logic [7:0]        dev;
  logic [ADDR_W-1:0] addr;
  logic [SLOT_W-1:0] idx, idx_next;
  logic              found, found_next;
  logic [SLOT_W-1:0] found_slot, found_slot_next;
  logic              fail, fail_next;

  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_dirty;
  tag_t               tag_mem [ENTRIES];
  tag_t               rd_data;

  logic              rd_en, wr_en, wr_dirty, clr_dirty, adv;
  logic [SLOT_W-1:0] wr_slot;
  logic              empty_any;
  logic [SLOT_W-1:0] empty_slot;
  logic              relevant, tag_match;
  chk_t              chk;

  res_t res, res_next;
  logic out_load, out_free;

  bbcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_dev   (dev),
    .req_addr  (addr),
    .ent_dev   (rd_data.dev),
    .chk       (chk)
  );

  // tag RAM: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tag_mem[idx];
    end
    if (wr_en) begin
      tag_mem[wr_slot] <= '{dev: dev[DEV_W-1:0], addr: addr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_dirty <= '0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_slot] <= 1'b1;
        entry_dirty[wr_slot] <= wr_dirty;
      end
      if (clr_dirty) begin
        entry_dirty[idx] <= 1'b0;
      end
    end
  end

  // first empty entry
  always_comb begin
    empty_any  = 1'b0;
    empty_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        empty_any  = 1'b1;
        empty_slot = SLOT_W'(i);
      end
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign relevant  = (op <= OP_WRITE) ? entry_valid[idx] : (entry_valid[idx] && entry_dirty[idx]);
  assign tag_match = (rd_data.dev == dev[DEV_W-1:0]) && (rd_data.addr == addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= opcode;
      dev  <= device;
      addr <= block_addr;
    end
    idx        <= idx_next;
    found      <= found_next;
    found_slot <= found_slot_next;
    fail       <= fail_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    found_next      = found;
    found_slot_next = found_slot;
    fail_next       = fail;
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_slot         = idx;
    wr_dirty        = 1'b0;
    clr_dirty       = 1'b0;
    adv             = 1'b0;
    out_load        = 1'b0;
    res_next        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CHECK;
          idx_next   = '0;
          found_next = 1'b0;
          fail_next  = 1'b0;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (op <= OP_FLUSH_DEV && !chk.req_dev_ok) begin
            out_load        = 1'b1;
            res_next.status = ST_BAD_DEV;
            res_next.last   = 1'b1;
            state_next      = S_IDLE;
          end else if (op <= OP_WRITE && !chk.req_addr_ok) begin
            out_load        = 1'b1;
            res_next.status = ST_BAD_ADDR;
            res_next.last   = 1'b1;
            state_next      = S_IDLE;
          end else if (op == OP_FILL) begin
            state_next = S_ALLOC;
          end else if (op <= OP_FLUSH_ALL) begin
            state_next = S_RD;
          end else begin
            out_load      = 1'b1;
            res_next.last = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      S_RD: begin
        if (relevant) begin
          rd_en      = 1'b1;
          state_next = S_CMP;
        end else begin
          adv = 1'b1;
        end
      end
      S_CMP: begin
        case (op)
          OP_READ, OP_WRITE: begin
            if (tag_match) begin
              found_next      = 1'b1;
              found_slot_next = idx;
              state_next      = S_FIN;
            end else begin
              adv = 1'b1;
            end
          end
          OP_FLUSH_DEV, OP_FLUSH_ALL: begin
            if ((op == OP_FLUSH_DEV) ? (rd_data.dev == dev[DEV_W-1:0]) : chk.ent_dev_ok) begin
              // hold here until the output register frees up
              if (out_free) begin
                out_load               = 1'b1;
                res_next.slot          = idx;
                res_next.writeback     = 1'b1;
                res_next.wb_device     = rd_data.dev;
                res_next.wb_block_addr = rd_data.addr;
                clr_dirty              = 1'b1;
                adv                    = 1'b1;
              end
            end else begin
              // flush all: dirty entry of a device no longer registered
              if (op == OP_FLUSH_ALL) begin
                fail_next = 1'b1;
              end
              adv = 1'b1;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          case (op)
            OP_READ: begin
              out_load      = 1'b1;
              res_next.hit  = found;
              res_next.slot = found ? found_slot : '0;
              res_next.last = 1'b1;
              state_next    = S_IDLE;
            end
            OP_WRITE: begin
              if (found) begin
                wr_en           = 1'b1;
                wr_slot         = found_slot;
                wr_dirty        = 1'b1;
                out_load        = 1'b1;
                res_next.slot   = found_slot;
                res_next.stored = 1'b1;
                res_next.last   = 1'b1;
                state_next      = S_IDLE;
              end else begin
                state_next = S_ALLOC;
              end
            end
            default: begin
              out_load        = 1'b1;
              res_next.status = fail ? ST_FLUSH_FAIL : ST_OK;
              res_next.last   = 1'b1;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          out_load      = 1'b1;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
          if (empty_any) begin
            wr_en           = 1'b1;
            wr_slot         = empty_slot;
            wr_dirty        = (op == OP_WRITE);
            res_next.slot   = empty_slot;
            res_next.stored = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (adv) begin
      if (idx == LAST_SLOT) begin
        state_next = S_FIN;
      end else begin
        idx_next   = idx + 1'b1;
        state_next = S_RD;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

  assign status        = res.status;
  assign hit           = res.hit;
  assign slot          = res.slot;
  assign stored        = res.stored;
  assign writeback     = res.writeback;
  assign wb_device     = res.wb_device;
  assign wb_block_addr = res.wb_block_addr;
  assign last          = res.last;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the block buffer cache directory: a directed
// script of lookups, fills, writes, flushes and register writes, then
// random traffic. Each response is compared field by field with a
// directory model kept in the bench.
// ---------------------------------------------------------------------------
module tb;
  import bbcd_pkg::*;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [CIDX_W-1:0] CFG_BLOCKS1 = CFG_BLOCKS0 + 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BLOCKS2 = CFG_BLOCKS0 + 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BLOCKS3 = CFG_BLOCKS0 + 3'd3;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 41;
  localparam int MAX_PRINTS    = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // typed rows carry a single response: status as given, last set, rest zero
  typedef struct packed {
    row_kind_t         kind;
    logic [CIDX_W-1:0] cidx;
    logic [2:0]        op;
    logic [7:0]        dev;
    logic [ADDR_W-1:0] val;
    logic              typed;
    logic [1:0]        st;
  } row_t;

  localparam int NROWS = 31;
  localparam row_t SCRIPT [NROWS] = '{
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd0,   64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_DEV, 8'd0,   64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_ALL, 8'd255, 64'd0,    1'b1, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_SPARE7,    8'd255, ADDR_MAX, 1'b1, ST_OK},
    '{ROW_CFG,  CFG_NUM_DEVICES, OP_READ,      8'd0,   64'd4,    1'b0, ST_OK},
    '{ROW_CFG,  CFG_BLOCKS0,     OP_READ,      8'd0,   ADDR_MAX, 1'b0, ST_OK},
    '{ROW_CFG,  CFG_BLOCKS1,     OP_READ,      8'd0,   64'd0,    1'b0, ST_OK},
    '{ROW_CFG,  CFG_BLOCKS2,     OP_READ,      8'd0,   64'd16,   1'b0, ST_OK},
    '{ROW_CFG,  CFG_BLOCKS3,     OP_READ,      8'd0,   64'd1000, 1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd1,   64'd0,    1'b1, ST_BAD_ADDR},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd0,   ADDR_MAX, 1'b1, ST_BAD_ADDR},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd0,   ADDR_MAX - 64'd1, 1'b1, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_WRITE,     8'd0,   ADDR_MAX - 64'd1, 1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd0,   ADDR_MAX - 64'd1, 1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FILL,      8'd2,   64'd15,   1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_WRITE,     8'd2,   64'd15,   1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_WRITE,     8'd3,   64'd999,  1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FILL,      8'd2,   64'd16,   1'b1, ST_BAD_ADDR},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd4,   64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FILL,      8'd255, 64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_DEV, 8'd0,   64'd0,    1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_ALL, 8'd0,   64'd0,    1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_WRITE,     8'd3,   64'd0,    1'b0, ST_OK},
    // device 3 drops out while its entry is still dirty
    '{ROW_CFG,  CFG_NUM_DEVICES, OP_READ,      8'd0,   64'd2,    1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_ALL, 8'd0,   64'd0,    1'b1, ST_FLUSH_FAIL},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_DEV, 8'd3,   64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_SPARE5,    8'd0,   64'd0,    1'b1, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_SPARE6,    8'd0,   64'd0,    1'b1, ST_OK},
    // count above the hardware device limit
    '{ROW_CFG,  CFG_NUM_DEVICES, OP_READ,      8'd0,   64'd7,    1'b0, ST_OK},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_READ,      8'd4,   64'd0,    1'b1, ST_BAD_DEV},
    '{ROW_ITEM, CFG_NUM_DEVICES, OP_FLUSH_ALL, 8'd0,   64'd0,    1'b0, ST_OK}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           opcode;
  logic [7:0]           device;
  logic [ADDR_W-1:0]    block_addr;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic                 stored;
  logic                 writeback;
  logic [DEV_W-1:0]     wb_device;
  logic [ADDR_W-1:0]    wb_block_addr;
  logic                 last;

  block_buffer_cache_directory dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .device        (device),
    .block_addr    (block_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .hit           (hit),
    .slot          (slot),
    .stored        (stored),
    .writeback     (writeback),
    .wb_device     (wb_device),
    .wb_block_addr (wb_block_addr),
    .last          (last)
  );

  // directory image and register copies
  logic              dir_valid [ENTRIES];
  logic              dir_dirty [ENTRIES];
  logic [DEV_W-1:0]  dir_dev   [ENTRIES];
  logic [ADDR_W-1:0] dir_addr  [ENTRIES];
  logic [2:0]        reg_ndev;
  logic [ADDR_W-1:0] reg_blocks [DEVICES];

  res_t step_results [$];
  res_t dir_responses [$];
  int   errors = 0;
  int   resp_count = 0;
  bit   hold_req;
  bit   no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic res_t mk_res(logic [1:0] st, logic h, logic [SLOT_W-1:0] s,
                                  logic sto, logic wb, logic [DEV_W-1:0] wdev,
                                  logic [ADDR_W-1:0] waddr, logic lst);
    res_t r;
    r.status        = st;
    r.hit           = h;
    r.slot          = s;
    r.stored        = sto;
    r.writeback     = wb;
    r.wb_device     = wdev;
    r.wb_block_addr = waddr;
    r.last          = lst;
    return r;
  endfunction

  function automatic bit dev_registered(logic [7:0] d);
    return (d < reg_ndev) && (d < DEVICES);
  endfunction

  function automatic int find_tag(logic [DEV_W-1:0] d, logic [ADDR_W-1:0] a);
    for (int i = 0; i < ENTRIES; i++)
      if (dir_valid[i] && dir_dev[i] == d && dir_addr[i] == a) return i;
    return -1;
  endfunction

  // Applies one request to the directory image and appends its responses
  // to step_results.
  function automatic void dir_apply(logic [2:0] op, logic [7:0] dev,
                                    logic [ADDR_W-1:0] addr);
    int s;
    logic [1:0] fin;
    s   = -1;
    fin = ST_OK;
    if (op <= OP_WRITE) begin
      if (!dev_registered(dev))
        step_results.push_back(mk_res(ST_BAD_DEV, 0, 0, 0, 0, 0, 0, 1));
      else if (addr >= reg_blocks[dev[1:0]])
        step_results.push_back(mk_res(ST_BAD_ADDR, 0, 0, 0, 0, 0, 0, 1));
      else if (op == OP_READ) begin
        s = find_tag(dev[1:0], addr);
        if (s >= 0)
          step_results.push_back(mk_res(ST_OK, 1, SLOT_W'(s), 0, 0, 0, 0, 1));
        else
          step_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 1));
      end else begin
        // fill never looks up, so it may duplicate a tag
        if (op == OP_WRITE) s = find_tag(dev[1:0], addr);
        for (int i = 0; i < ENTRIES && s < 0; i++)
          if (!dir_valid[i]) s = i;
        if (s < 0) begin
          step_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          dir_valid[s] = 1'b1;
          dir_dirty[s] = (op == OP_WRITE);
          dir_dev[s]   = dev[1:0];
          dir_addr[s]  = addr;
          step_results.push_back(mk_res(ST_OK, 0, SLOT_W'(s), 1, 0, 0, 0, 1));
        end
      end
    end else if (op == OP_FLUSH_DEV) begin
      if (!dev_registered(dev)) begin
        step_results.push_back(mk_res(ST_BAD_DEV, 0, 0, 0, 0, 0, 0, 1));
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (dir_valid[i] && dir_dirty[i] && dir_dev[i] == dev[1:0]) begin
            step_results.push_back(mk_res(ST_OK, 0, SLOT_W'(i), 0, 1, dir_dev[i],
                                          dir_addr[i], 0));
            dir_dirty[i] = 1'b0;
          end
        step_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 1));
      end
    end else if (op == OP_FLUSH_ALL) begin
      for (int i = 0; i < ENTRIES; i++)
        if (dir_valid[i] && dir_dirty[i]) begin
          // owner no longer registered: skip, stays dirty
          if (!dev_registered({6'd0, dir_dev[i]})) begin
            fin = ST_FLUSH_FAIL;
          end else begin
            step_results.push_back(mk_res(ST_OK, 0, SLOT_W'(i), 0, 1, dir_dev[i],
                                          dir_addr[i], 0));
            dir_dirty[i] = 1'b0;
          end
        end
      step_results.push_back(mk_res(fin, 0, 0, 0, 0, 0, 0, 1));
    end else begin
      step_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 0, 0, 1));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want)
      report($sformatf("response %0d %s got %0h want %0h", resp_count, name, got, want));
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUM_DEVICES) reg_ndev = data[2:0];
    else if (idx >= CFG_BLOCKS0 && idx <= CFG_BLOCKS3)
      reg_blocks[DEV_W'(idx - CFG_BLOCKS0)] = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offers one request; on acceptance queues either the typed response or
  // the directory model's responses.
  task automatic push_item(logic [2:0] op, logic [7:0] dev, logic [ADDR_W-1:0] addr,
                           logic typed, logic [1:0] st);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    opcode     = op;
    device     = dev;
    block_addr = addr;
    do @(posedge clk); while (!in_ready);
    step_results.delete();
    dir_apply(op, dev, addr);
    if (typed)
      dir_responses.push_back(mk_res(st, 0, 0, 0, 0, 0, 0, 1));
    else
      foreach (step_results[i]) dir_responses.push_back(step_results[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (dir_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_blocks();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 64'd8;
    if (r < 65) return ADDR_MAX;
    if (r < 75) return 64'd0;
    if (r < 85) return 64'd1;
    return {$urandom, $urandom};
  endfunction

  task automatic random_item();
    int r;
    logic [2:0] op;
    logic [7:0] dev;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(99);
    if (r < 30)      op = OP_READ;
    else if (r < 42) op = OP_FILL;
    else if (r < 72) op = OP_WRITE;
    else if (r < 84) op = OP_FLUSH_DEV;
    else if (r < 93) op = OP_FLUSH_ALL;
    else             op = 3'($urandom_range(OP_FLUSH_ALL + 1, OP_SPARE7));
    r = $urandom_range(99);
    if (r < 85)      dev = 8'($urandom_range(0, DEVICES - 1));
    else if (r < 93) dev = 8'($urandom_range(4, 7));
    else             dev = 8'($urandom_range(0, 255));
    // small pool so reads and writes keep hitting resident tags
    r = $urandom_range(99);
    if (r < 80)      addr = 64'($urandom_range(0, 5));
    else if (r < 88) addr = reg_blocks[dev[1:0]] - 64'd1;
    else if (r < 94) addr = reg_blocks[dev[1:0]];
    else             addr = {$urandom, $urandom};
    push_item(op, dev, addr, 1'b0, ST_OK);
  endtask

  // response side: random back-pressure, one long hold on request
  initial begin
    int gap;
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req && !held) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        @(negedge clk);
        out_ready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : response_check
    res_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = mk_res(status, hit, slot, stored, writeback, wb_device, wb_block_addr, last);
      if (dir_responses.size() == 0) begin
        report($sformatf("response %0d arrived with nothing outstanding", resp_count));
      end else begin
        want = dir_responses.pop_front();
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("hit", 64'(got.hit), 64'(want.hit));
        check_field("slot", 64'(got.slot), 64'(want.slot));
        check_field("stored", 64'(got.stored), 64'(want.stored));
        check_field("writeback", 64'(got.writeback), 64'(want.writeback));
        check_field("wb_device", 64'(got.wb_device), 64'(want.wb_device));
        check_field("wb_block_addr", got.wb_block_addr, want.wb_block_addr);
        check_field("last", 64'(got.last), 64'(want.last));
      end
      resp_count++;
    end
  end

  initial begin
    logic [2:0] ndev;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = '0;
    device     = '0;
    block_addr = '0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    reg_ndev   = '0;
    for (int d = 0; d < DEVICES; d++) reg_blocks[d] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_dev[i]   = '0;
      dir_addr[i]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        drain();
        cfg_write(SCRIPT[i].cidx, SCRIPT[i].val);
      end else begin
        push_item(SCRIPT[i].op, SCRIPT[i].dev, SCRIPT[i].val, SCRIPT[i].typed,
                  SCRIPT[i].st);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        // first phase fills the remaining entries from the small tag pool
        cfg_write(CFG_NUM_DEVICES, 64'd4);
        for (int d = 0; d < DEVICES; d++)
          cfg_write(CFG_BLOCKS0 + CIDX_W'(d), 64'd8);
      end else begin
        ndev = ($urandom_range(99) < 60) ? 3'd4 : 3'($urandom_range(0, 7));
        // upper bits of the count register are don't-care
        cfg_write(CFG_NUM_DEVICES, ({$urandom, $urandom} & ~64'h7) | 64'(ndev));
        for (int d = 0; d < DEVICES; d++)
          cfg_write(CFG_BLOCKS0 + CIDX_W'(d), pick_blocks());
      end
      if (ph == 2) hold_req = 1'b1;
      no_gaps = (ph == 4);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && dir_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
